// ===== hw/rtl/shc_pkg.sv =====
// shared types and constants for the sha-256 block compression core
`default_nettype none

package shc_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

   typedef logic [31:0] shc_word_type;

   // one queued message word with its classification
   typedef struct packed {
      shc_word_type word;
      logic         reload;
      logic         last;
   } shc_entry_type;

   localparam shc_word_type INIT_VALUE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam shc_word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

// ===== hw/rtl/shc_front.sv =====
// front end: word counter and classification of incoming message words
`default_nettype none

module shc_front
   import shc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire shc_word_type  req_message_word,
   input  wire logic          req_new_message,
   input  wire logic          queue_full,
   output logic               busy,
   output logic               push,
   output shc_entry_type      push_entry
);

   logic [3:0] count_ff;
   logic [3:0] count_in;

   assign busy = queue_full;
   assign push = start & ~queue_full;

   always_comb begin
      push_entry.word   = req_message_word;
      // the flag only counts on the first word of a block
      push_entry.reload = req_new_message & (count_ff == 4'd0);
      push_entry.last   = (count_ff == 4'd15);
      count_in          = push ? count_ff + 4'd1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/shc_queue.sv =====
// short word queue between front end and compression engine
`default_nettype none

module shc_queue
   import shc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire shc_entry_type  push_entry,
   input  wire logic           pop,
   output logic                full,
   output logic                empty,
   output shc_entry_type       pop_entry
);

   shc_entry_type                mem_ff [QueueDepth];
   logic [QueuePtrBits-1:0]      wr_ptr_ff;
   logic [QueuePtrBits-1:0]      wr_ptr_in;
   logic [QueuePtrBits-1:0]      rd_ptr_ff;
   logic [QueuePtrBits-1:0]      rd_ptr_in;
   logic [QueuePtrBits:0]        fill_ff;
   logic [QueuePtrBits:0]        fill_in;
   logic                         do_push;
   logic                         do_pop;

   assign full      = (fill_ff == (QueuePtrBits+1)'(QueueDepth));
   assign empty     = (fill_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push = push & ~full;
      do_pop  = pop & ~empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + (QueuePtrBits+1)'(do_push) - (QueuePtrBits+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/shc_back.sv =====
// compression engine: schedule window, round datapath, chaining value, digest output
`default_nettype none

module shc_back
   import shc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           queue_empty,
   input  wire shc_entry_type  pop_entry,
   output logic                pop,
   output logic                rsp_valid,
   output shc_word_type        rsp_digest_word,
   output logic [2:0]          rsp_digest_index,
   output logic                rsp_digest_last
);

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   function automatic shc_word_type rotr(input shc_word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   logic [1:0]    state_ff;
   logic [1:0]    state_in;
   logic [5:0]    round_ff;
   logic [5:0]    round_in;
   logic [2:0]    idx_ff;
   logic [2:0]    idx_in;
   shc_word_type  win_ff   [16];
   shc_word_type  win_in   [16];
   shc_word_type  v_ff     [8];
   shc_word_type  v_in     [8];
   shc_word_type  chain_ff [8];
   shc_word_type  chain_in [8];
   logic          valid_ff;
   logic          valid_in;
   shc_word_type  word_ff;
   shc_word_type  word_in;
   logic [2:0]    index_ff;
   logic [2:0]    index_in;
   logic          last_ff;
   logic          last_in;

   shc_word_type  s0;
   shc_word_type  s1;
   shc_word_type  w_next;
   shc_word_type  big0;
   shc_word_type  big1;
   shc_word_type  ch;
   shc_word_type  maj;
   shc_word_type  t1;
   shc_word_type  t2;

   assign rsp_valid        = valid_ff;
   assign rsp_digest_word  = word_ff;
   assign rsp_digest_index = index_ff;
   assign rsp_digest_last  = last_ff;

   // message expansion and one round
   always_comb begin
      s0     = rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      s1     = rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
      w_next = win_ff[0] + s0 + win_ff[9] + s1;
      big1   = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch     = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1     = v_ff[7] + big1 + ch + ROUND_K[round_ff] + win_ff[0];
      big0   = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj    = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2     = big0 + maj;
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      win_in   = win_ff;
      v_in     = v_ff;
      chain_in = chain_ff;
      valid_in = 1'b0;
      word_in  = word_ff;
      index_in = index_ff;
      last_in  = last_ff;
      pop      = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (!queue_empty) begin
               pop = 1'b1;
               if (pop_entry.reload) begin
                  chain_in = INIT_VALUE;
               end
               for (int i = 0; i < 15; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[15] = pop_entry.word;
               if (pop_entry.last) begin
                  if (pop_entry.reload) begin
                     v_in = INIT_VALUE;
                  end else begin
                     v_in = chain_ff;
                  end
                  round_in = 6'd0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = w_next;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + v_ff[i];
            end
            idx_in   = 3'd0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            valid_in = 1'b1;
            word_in  = chain_ff[idx_ff];
            index_in = idx_ff;
            last_in  = (idx_ff == 3'd7);
            idx_in   = idx_ff + 3'd1;
            if (idx_ff == 3'd7) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      round_ff <= round_in;
      idx_ff   <= idx_in;
      win_ff   <= win_in;
      v_ff     <= v_in;
      word_ff  <= word_in;
      index_ff <= index_in;
      last_ff  <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         chain_ff <= INIT_VALUE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sha256_block_compress_core.sv =====
// top level of the sha-256 block compression core
//
// input: one 32-bit message word per accepted start (start high, busy low), sixteen
//   words make a block; req_new_message on the first word of a block reloads the
//   standard initial hash value before that block, and is ignored on later words
// output: after each sixteenth word the eight updated chaining words come out on
//   rsp_digest_word, index 0 first, one per cycle with rsp_valid high, rsp_digest_last
//   marking index 7; the receiver cannot stall, every strobed word is taken
// structure: a front end counts and tags words, a four-entry queue decouples it from
//   the compression engine, which shifts words into a 16-word schedule window and
//   then runs one round per cycle on a single round datapath
// sequence: each block takes 16 word loads, 64 rounds, one add and 8 output words in
//   that order on the single round datapath; busy rises only when the queue is full,
//   so up to four words of the next block are taken during rounds
// reset: synchronous, clears the word count, queue and engine state and loads the
//   initial hash value
`default_nettype none

module sha256_block_compress_core
   import shc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire shc_word_type  req_message_word,
   input  wire logic          req_new_message,
   output logic               rsp_valid,
   output shc_word_type       rsp_digest_word,
   output logic [2:0]         rsp_digest_index,
   output logic               rsp_digest_last
);

   // front end to queue
   logic           push;
   shc_entry_type  push_entry;
   logic           queue_full;

   // queue to engine
   logic           pop;
   logic           queue_empty;
   shc_entry_type  pop_entry;

   shc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_message_word (req_message_word),
      .req_new_message  (req_new_message),
      .queue_full       (queue_full),
      .busy             (busy),
      .push             (push),
      .push_entry       (push_entry)
   );

   shc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .pop_entry  (pop_entry)
   );

   // engine drives the registered result word directly
   shc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .pop_entry        (pop_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

endmodule

`default_nettype wire

// ===== tb/tb_sha256_block_compress_core.sv =====
// self-checking testbench for the sha-256 block compression core
`default_nettype none

module tb_sha256_block_compress_core
   import shc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no word taken and no digest word seen before the run is abandoned
   localparam int unsigned StallLimit = 2000;
   // quiet cycles after the last digest word
   localparam int unsigned DrainCycles = 120;
   localparam int unsigned RandomBlocks = 13;

   // one message word waiting to be offered
   typedef struct {
      shc_word_type word;
      logic         fresh;
   } msg_word_type;

   // one chaining word still to come out
   typedef struct {
      shc_word_type word;
      logic [2:0]   index;
      logic         last;
   } digest_exp_type;

   // standard initial hash value and round constants, kept apart from the package
   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] K_WORDS [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // directed block: extremes, single set bits, and a padded "abc" pattern
   localparam logic [31:0] EDGE_WORDS [16] = '{
      32'hffffffff, 32'h00000000, 32'h80000000, 32'h00000001,
      32'h61626380, 32'h00000000, 32'hffffffff, 32'h7fffffff,
      32'hfffffffe, 32'h55555555, 32'haaaaaaaa, 32'h00000000,
      32'hffffffff, 32'h0000ffff, 32'hffff0000, 32'h00000018
   };

   logic         clock;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   shc_word_type req_message_word = '0;
   logic         req_new_message = 1'b0;
   logic         rsp_valid;
   shc_word_type rsp_digest_word;
   logic [2:0]   rsp_digest_index;
   logic         rsp_digest_last;

   // predictor state: chaining words, collected block and position within it
   logic [31:0]  hash_state [8];
   logic [31:0]  block_words [16];
   logic [3:0]   word_pos;

   msg_word_type    word_q [$];
   digest_exp_type  digest_q [$];
   int unsigned  words_taken = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  fail_count = 0;

   sha256_block_compress_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_message_word (req_message_word),
      .req_new_message  (req_new_message),
      .rsp_valid        (rsp_valid),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
      return (v >> n) | (v << (32 - n));
   endfunction

   // one full compression of the collected block into the chaining words
   task automatic fold_block();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = block_words[t];
      // message schedule expansion
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = w[t-16] + s0 + w[t-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      // the 64 rounds, working variables a..h held in v[0]..v[7]
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_WORDS[t] + w[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
   endtask

   // a word taken by the block: store it, and on the sixteenth queue eight digest words
   task automatic take_word(input logic [31:0] word, input logic fresh);
      digest_exp_type d;
      // the reload flag only counts on the first word of a block
      if (word_pos == 4'd0 && fresh) begin
         for (int i = 0; i < 8; i++) hash_state[i] = IV_WORDS[i];
      end
      block_words[word_pos] = word;
      if (word_pos != 4'd15) begin
         word_pos = word_pos + 4'd1;
      end else begin
         word_pos = 4'd0;
         fold_block();
         for (int k = 0; k < 8; k++) begin
            d.word = hash_state[k];
            d.index = 3'(k);
            d.last = (k == 7);
            digest_q.push_back(d);
         end
      end
   endtask

   // random word with extra weight on all zeros and all ones
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h00000000;
         1: return 32'hffffffff;
         default: return $urandom();
      endcase
   endfunction

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // reset once, at the start of the run
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // word driver: offers the next queued word, holds it while busy, and idles at
   // random except in one steady stretch in the middle of the run
   always @(posedge clock) begin : word_driver
      msg_word_type nxt;
      logic      gap;
      if (reset) begin
         start <= 1'b0;
         for (int i = 0; i < 8; i++) hash_state[i] = IV_WORDS[i];
         word_pos = 4'd0;
      end else begin
         if (start && !busy) begin
            take_word(req_message_word, req_new_message);
            words_taken++;
         end
         // a new choice only when nothing is on offer or the offer was just taken
         if (!start || !busy) begin
            gap = ($urandom_range(99) < 32) && !(words_taken >= 96 && words_taken < 160);
            if (word_q.size() != 0 && !gap) begin
               nxt = word_q.pop_front();
               start <= 1'b1;
               req_message_word <= nxt.word;
               req_new_message <= nxt.fresh;
            end else begin
               // junk on the data ports while start is low
               start <= 1'b0;
               req_message_word <= $urandom();
               req_new_message <= 1'($urandom_range(1));
            end
         end
      end
   end

   // digest monitor: every strobed word is compared with the oldest expectation
   always @(posedge clock) begin : digest_monitor
      digest_exp_type d;
      if (!reset && rsp_valid === 1'b1) begin
         if (digest_q.size() == 0) begin
            $error("unexpected digest word %h at index %0d", rsp_digest_word,
                   rsp_digest_index);
            fail_count++;
         end else begin
            d = digest_q.pop_front();
            if (rsp_digest_word !== d.word) begin
               $error("digest_word mismatch: expected %h, got %h", d.word,
                      rsp_digest_word);
               fail_count++;
            end
            if (rsp_digest_index !== d.index) begin
               $error("digest_index mismatch: expected %0d, got %0d", d.index,
                      rsp_digest_index);
               fail_count++;
            end
            if (rsp_digest_last !== d.last) begin
               $error("digest_last mismatch: expected %b, got %b", d.last,
                      rsp_digest_last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no word taken and no digest word out
   always @(posedge clock) begin : stall_watchdog
      if (reset || (start && !busy) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      msg_word_type m;
      // directed block straight after reset, no reload flag on the first word;
      // the flag is set on several later words, where it must be ignored
      for (int i = 0; i < 16; i++) begin
         m.word = EDGE_WORDS[i];
         m.fresh = (i == 3 || i == 9 || i == 15);
         word_q.push_back(m);
      end
      // random blocks: the first chains on from the directed one, the second
      // restarts from the initial value with more blocks following
      for (int b = 0; b < RandomBlocks; b++) begin
         for (int i = 0; i < 16; i++) begin
            m.word = pick_word();
            if (i != 0) m.fresh = ($urandom_range(3) == 0);
            else if (b == 0) m.fresh = 1'b0;
            else if (b == 1) m.fresh = 1'b1;
            else m.fresh = 1'($urandom_range(1));
            word_q.push_back(m);
         end
      end
      // wait for every word to go in and every digest word to come out
      @(negedge clock);
      while (reset || word_q.size() != 0 || start || digest_q.size() != 0)
         @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sha256_block_compress_core.f =====
hw/rtl/shc_pkg.sv
hw/rtl/shc_front.sv
hw/rtl/shc_queue.sv
hw/rtl/shc_back.sv
hw/rtl/sha256_block_compress_core.sv
tb/tb_sha256_block_compress_core.sv
